[hdl/tcpr_pkg.sv]
// Types and constants shared by the TCP client receive tracker.
`default_nettype none

package tcpr_pkg;

    localparam int unsigned SEQ_W          = 32;
    localparam int unsigned ADDR_W         = 32;
    localparam int unsigned PORT_W         = 16;
    localparam int unsigned LEN_W          = 16;
    localparam int unsigned FLAGS_W        = 8;
    localparam int unsigned STORE_OFFSET_W = 22;
    localparam int unsigned CFG_INDEX_W    = 2;
    localparam int unsigned CFG_DATA_W     = 32;

    localparam int unsigned QUEUE_DEPTH    = 2;
    localparam int unsigned QUEUE_PTR_W    = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CNT_W    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [FLAGS_W-1:0] FLAG_FIN = 8'h01;
    localparam logic [FLAGS_W-1:0] FLAG_SYN = 8'h02;
    localparam logic [FLAGS_W-1:0] FLAG_ACK = 8'h10;

    typedef enum logic [1:0] {
        FUNC_SEGMENT = 2'd0,
        FUNC_OPEN    = 2'd1,
        FUNC_SENT    = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        SK_NONE = 2'd0,
        SK_ACK  = 2'd1,
        SK_SYN  = 2'd2,
        SK_DATA = 2'd3
    } send_kind_t;

    typedef enum logic [1:0] {
        CS_CLOSED      = 2'd0,
        CS_SYN_SENT    = 2'd1,
        CS_ESTABLISHED = 2'd2
    } conn_state_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SERVER_ADDRESS   = 2'd0,
        CFG_CLIENT_PORT      = 2'd1,
        CFG_INITIAL_SEQUENCE = 2'd2
    } cfg_index_t;

    // What the front has made of an item.
    typedef enum logic [1:0] {
        IC_NONE    = 2'd0,
        IC_OPEN    = 2'd1,
        IC_SENT    = 2'd2,
        IC_SEGMENT = 2'd3
    } item_class_t;

    typedef struct packed {
        item_class_t      cls;
        logic             syn_ack;
        logic             fin;
        logic [LEN_W-1:0] len;
        logic [SEQ_W-1:0] seq;   // peer sequence, or initial local sequence on open
        logic [SEQ_W-1:0] ack;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

`default_nettype wire

[hdl/tcpr_if.sv]
// Channel interfaces of the TCP client receive tracker.
`default_nettype none

interface tcpr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [31:0] source_address;
    logic [15:0] dest_port;
    logic [7:0]  tcp_flags;
    logic [31:0] peer_sequence_in;
    logic [31:0] peer_ack_in;
    logic [15:0] byte_count;

    modport source (output valid, func, source_address, dest_port, tcp_flags,
                    peer_sequence_in, peer_ack_in, byte_count, input ready);
    modport sink (input valid, func, source_address, dest_port, tcp_flags,
                  peer_sequence_in, peer_ack_in, byte_count, output ready);
endinterface

interface tcpr_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  send_kind;
    logic [31:0] send_sequence;
    logic [31:0] send_ack_number;
    logic [1:0]  connection_state;
    logic        store_accepted;
    logic [21:0] store_offset;
    logic        download_done;
    logic        last_of_run;

    modport source (output valid, send_kind, send_sequence, send_ack_number,
                    connection_state, store_accepted, store_offset, download_done,
                    last_of_run, input ready);
    modport sink (input valid, send_kind, send_sequence, send_ack_number,
                  connection_state, store_accepted, store_offset, download_done,
                  last_of_run, output ready);
endinterface

interface tcpr_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hdl/tcpr_front.sv]
// Front end: configuration registers, input acceptance and item classification.
`default_nettype none

module tcpr_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    tcpr_in_if.sink                item,
    tcpr_cfg_if.sink               cfg,
    input  wire tcpr_pkg::queue_status_t status,
    output logic                   push,
    output tcpr_pkg::entry_t       entry
);

    logic [tcpr_pkg::ADDR_W-1:0] server_address_reg;
    logic [tcpr_pkg::PORT_W-1:0] client_port_reg;
    logic [tcpr_pkg::SEQ_W-1:0]  initial_sequence_reg;
    logic                        match;

    assign cfg.ready  = 1'b1;
    assign item.ready = !status.full;
    assign push       = item.valid && item.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            server_address_reg   <= '0;
            client_port_reg      <= '0;
            initial_sequence_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (tcpr_pkg::cfg_index_t'(cfg.index))
                tcpr_pkg::CFG_SERVER_ADDRESS:   server_address_reg   <= cfg.data;
                tcpr_pkg::CFG_CLIENT_PORT:      client_port_reg      <= cfg.data[tcpr_pkg::PORT_W-1:0];
                tcpr_pkg::CFG_INITIAL_SEQUENCE: initial_sequence_reg <= cfg.data;
                default:                        ;
            endcase
        end
    end

    assign match = (item.source_address == server_address_reg)
                && (item.dest_port == client_port_reg);

    always_comb
    begin
        entry.syn_ack = ((item.tcp_flags & tcpr_pkg::FLAG_SYN) != '0)
                     && ((item.tcp_flags & tcpr_pkg::FLAG_ACK) != '0);
        entry.fin     = (item.tcp_flags & tcpr_pkg::FLAG_FIN) != '0;
        entry.len     = item.byte_count;
        entry.seq     = item.peer_sequence_in;
        entry.ack     = item.peer_ack_in;
        case (tcpr_pkg::func_t'(item.func))
            tcpr_pkg::FUNC_SEGMENT: entry.cls = match ? tcpr_pkg::IC_SEGMENT : tcpr_pkg::IC_NONE;
            tcpr_pkg::FUNC_OPEN:
            begin
                entry.cls = tcpr_pkg::IC_OPEN;
                entry.seq = initial_sequence_reg;
            end
            tcpr_pkg::FUNC_SENT:    entry.cls = tcpr_pkg::IC_SENT;
            default:                entry.cls = tcpr_pkg::IC_NONE;
        endcase
    end

endmodule

`default_nettype wire

[hdl/tcpr_queue.sv]
// Two-entry queue that decouples the front end from the back end.
`default_nettype none

module tcpr_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire tcpr_pkg::entry_t   entry,
    input  wire logic               pop,
    output tcpr_pkg::entry_t        head,
    output tcpr_pkg::queue_status_t status
);

    tcpr_pkg::entry_t                  mem_reg [tcpr_pkg::QUEUE_DEPTH];
    logic [tcpr_pkg::QUEUE_PTR_W-1:0]  wr_ptr_reg;
    logic [tcpr_pkg::QUEUE_PTR_W-1:0]  rd_ptr_reg;
    logic [tcpr_pkg::QUEUE_CNT_W-1:0]  count_reg;
    logic [tcpr_pkg::QUEUE_CNT_W-1:0]  count_next;

    assign status.full  = count_reg == tcpr_pkg::QUEUE_CNT_W'(tcpr_pkg::QUEUE_DEPTH);
    assign status.empty = count_reg == '0;
    assign head         = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= entry;
    end

endmodule

`default_nettype wire

[hdl/tcpr_back.sv]
// Back end: connection state, sequence tracking, buffer offsets and result register.
`default_nettype none

module tcpr_back #(
    parameter int unsigned BUFFER_BYTES = 4194304
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire tcpr_pkg::entry_t        head,
    input  wire tcpr_pkg::queue_status_t status,
    output logic                         pop,
    tcpr_out_if.source                   result
);

    localparam int unsigned OFF_W = $clog2(BUFFER_BYTES);
    localparam int unsigned SUM_W = ((OFF_W > tcpr_pkg::LEN_W) ? OFF_W : tcpr_pkg::LEN_W) + 1;
    localparam logic [SUM_W-1:0] LIMIT = SUM_W'(BUFFER_BYTES);

    tcpr_pkg::conn_state_t       conn_state_reg, conn_state_next;
    logic [tcpr_pkg::SEQ_W-1:0]  local_seq_reg, local_seq_next;
    logic [tcpr_pkg::SEQ_W-1:0]  peer_seq_reg, peer_seq_next;
    logic [OFF_W-1:0]            bytes_reg, bytes_next;
    logic                        done_reg, done_next;
    logic                        fin_pending_reg, fin_pending_next;
    logic                        out_valid_reg, out_valid_next;

    tcpr_pkg::send_kind_t        kind_reg, kind_next;
    logic [tcpr_pkg::SEQ_W-1:0]  seq_out_reg, seq_out_next;
    logic [tcpr_pkg::SEQ_W-1:0]  ack_out_reg, ack_out_next;
    logic                        store_reg, store_next;
    logic [OFF_W-1:0]            offset_reg, offset_next;
    logic                        last_reg, last_next;

    logic                        can_emit;
    logic                        emit;
    logic                        has_len;
    logic [SUM_W-1:0]            fill_sum;
    logic [tcpr_pkg::SEQ_W-1:0]  peer_data;
    logic [tcpr_pkg::SEQ_W-1:0]  peer_fin;

    assign can_emit = !out_valid_reg || result.ready;
    assign emit     = can_emit && (fin_pending_reg || !status.empty);
    assign pop      = can_emit && !fin_pending_reg && !status.empty;

    assign has_len   = head.len != '0;
    assign fill_sum  = SUM_W'(bytes_reg) + SUM_W'(head.len);
    assign peer_data = head.seq + tcpr_pkg::SEQ_W'(head.len);
    assign peer_fin  = (has_len ? peer_data : peer_seq_reg) + 1'b1;

    always_comb
    begin
        conn_state_next  = conn_state_reg;
        local_seq_next   = local_seq_reg;
        peer_seq_next    = peer_seq_reg;
        bytes_next       = bytes_reg;
        done_next        = done_reg;
        fin_pending_next = fin_pending_reg;
        kind_next        = tcpr_pkg::SK_NONE;
        seq_out_next     = '0;
        ack_out_next     = '0;
        store_next       = 1'b0;
        offset_next      = '0;
        last_next        = 1'b1;

        if (fin_pending_reg)
        begin
            // second beat: ACK for the FIN, state already final
            fin_pending_next = 1'b0;
            kind_next        = tcpr_pkg::SK_ACK;
            seq_out_next     = local_seq_reg;
            ack_out_next     = peer_seq_reg;
        end
        else
        begin
            case (head.cls)
                tcpr_pkg::IC_OPEN:
                begin
                    local_seq_next  = head.seq;
                    peer_seq_next   = '0;
                    bytes_next      = '0;
                    done_next       = 1'b0;
                    conn_state_next = tcpr_pkg::CS_SYN_SENT;
                    kind_next       = tcpr_pkg::SK_SYN;
                    seq_out_next    = head.seq;
                end
                tcpr_pkg::IC_SENT:
                begin
                    kind_next      = tcpr_pkg::SK_DATA;
                    seq_out_next   = local_seq_reg;
                    ack_out_next   = peer_seq_reg;
                    local_seq_next = local_seq_reg + tcpr_pkg::SEQ_W'(head.len);
                end
                tcpr_pkg::IC_SEGMENT:
                begin
                    if (conn_state_reg == tcpr_pkg::CS_SYN_SENT)
                    begin
                        if (head.syn_ack)
                        begin
                            peer_seq_next   = head.seq + 1'b1;
                            local_seq_next  = head.ack;
                            conn_state_next = tcpr_pkg::CS_ESTABLISHED;
                        end
                    end
                    else if (conn_state_reg == tcpr_pkg::CS_ESTABLISHED)
                    begin
                        if (has_len)
                        begin
                            if (fill_sum < LIMIT)
                            begin
                                store_next  = 1'b1;
                                offset_next = bytes_reg;
                                bytes_next  = fill_sum[OFF_W-1:0];
                            end
                            peer_seq_next = peer_data;
                            kind_next     = tcpr_pkg::SK_ACK;
                            seq_out_next  = local_seq_reg;
                            ack_out_next  = peer_data;
                        end
                        if (head.fin)
                        begin
                            peer_seq_next   = peer_fin;
                            conn_state_next = tcpr_pkg::CS_CLOSED;
                            done_next       = 1'b1;
                            if (has_len)
                            begin
                                // hold the FIN ACK for the next beat
                                fin_pending_next = 1'b1;
                                last_next        = 1'b0;
                            end
                            else
                            begin
                                kind_next    = tcpr_pkg::SK_ACK;
                                seq_out_next = local_seq_reg;
                                ack_out_next = peer_fin;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end

        if (emit)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conn_state_reg  <= tcpr_pkg::CS_CLOSED;
            local_seq_reg   <= '0;
            peer_seq_reg    <= '0;
            bytes_reg       <= '0;
            done_reg        <= 1'b0;
            fin_pending_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (emit)
            begin
                conn_state_reg  <= conn_state_next;
                local_seq_reg   <= local_seq_next;
                peer_seq_reg    <= peer_seq_next;
                bytes_reg       <= bytes_next;
                done_reg        <= done_next;
                fin_pending_reg <= fin_pending_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            kind_reg    <= kind_next;
            seq_out_reg <= seq_out_next;
            ack_out_reg <= ack_out_next;
            store_reg   <= store_next;
            offset_reg  <= offset_next;
            last_reg    <= last_next;
        end
    end

    // Connection state and done flag of a result are those after the whole item.
    logic [1:0] state_out_reg;
    logic       done_out_reg;

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            state_out_reg <= conn_state_next;
            done_out_reg  <= done_next;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.send_kind        = kind_reg;
    assign result.send_sequence    = seq_out_reg;
    assign result.send_ack_number  = ack_out_reg;
    assign result.connection_state = state_out_reg;
    assign result.store_accepted   = store_reg;
    assign result.store_offset     = tcpr_pkg::STORE_OFFSET_W'(offset_reg);
    assign result.download_done    = done_out_reg;
    assign result.last_of_run      = last_reg;

endmodule

`default_nettype wire

[hdl/tcp_client_receive_tracker.sv]
// Top level of the TCP client receive tracker.
`default_nettype none

// Tracks the client side of a plain TCP download: open, sent-data and
// received-segment items go in on the item channel, send requests with the
// connection state and payload buffer offsets come out on the result channel.
// The front end takes one item per cycle into a two-entry queue while that
// queue has room; the back end issues one result per cycle through its output
// register while the result channel is ready; a segment that carries both payload
// and FIN gives two result beats. An accepted item is written into the queue,
// and the back end loads its first result from the queue head into the output
// register. Registers are written on the cfg channel, which is always ready,
// and must only be written while idle.
module tcp_client_receive_tracker #(
    parameter int unsigned BUFFER_BYTES = 4194304
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    tcpr_in_if.sink    item,
    tcpr_out_if.source result,
    tcpr_cfg_if.sink   cfg
);

    tcpr_pkg::entry_t        entry;
    tcpr_pkg::entry_t        head;
    tcpr_pkg::queue_status_t status;
    logic                    push;
    logic                    pop;

    tcpr_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cfg    (cfg),
        .status (status),
        .push   (push),
        .entry  (entry)
    );

    tcpr_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .entry  (entry),
        .pop    (pop),
        .head   (head),
        .status (status)
    );

    tcpr_back #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .status (status),
        .pop    (pop),
        .result (result)
    );

    // A non-final beat only comes from payload plus FIN, which closes the download.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.last_of_run)
        |-> (result.connection_state == tcpr_pkg::CS_CLOSED) && result.download_done)
    else $error("non-final result without a closing FIN");

    // Stored payload is always acknowledged.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.store_accepted)
        |-> (result.send_kind == tcpr_pkg::SK_ACK))
    else $error("stored payload without an ACK");

    // A stored offset lies inside the buffer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.store_accepted)
        |-> (32'(result.store_offset) < 32'(BUFFER_BYTES)))
    else $error("store offset beyond the buffer");

    // A queue with room never refuses an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!item.ready) |-> $past(item.valid) || $past(result.valid))
    else $error("item refused with nothing in flight");

endmodule

`default_nettype wire

[sim/tb_tcp_client_receive_tracker.sv]
// Self-checking testbench for the TCP client receive tracker: directed table, then random downloads.
`timescale 1ns / 1ps

module tb_tcp_client_receive_tracker;

    localparam int unsigned BUF_BYTES     = 4194304;
    localparam int          RESET_CYCLES  = 7;
    localparam int          SETTLE_CYCLES = 6;
    localparam int          HOLD_CYCLES   = 200;
    localparam int          QUIET_LIMIT   = 2000;
    localparam int          PHASE_ITEMS   = 212;

    localparam logic [1:0]                   FUNC_UNUSED = 2'd3;
    localparam logic [tcpr_pkg::FLAGS_W-1:0] FLAG_PSH    = 8'h08;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] src;
        logic [15:0] dport;
        logic [7:0]  flags;
        logic [31:0] seq;
        logic [31:0] ackn;
        logic [15:0] len;
    } seg_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] seq;
        logic [31:0] ackn;
        logic [1:0]  state;
        logic        acc;
        logic [21:0] off;
        logic        done;
        logic        last;
    } tx_req_t;

    typedef struct packed {
        seg_item_t it;
        logic      typed;
        tx_req_t   want;
    } dir_row_t;

    logic clk;
    logic rst_n;

    tcpr_in_if  item_if ();
    tcpr_out_if res_if ();
    tcpr_cfg_if cfg_if ();

    tcp_client_receive_tracker #(
        .BUFFER_BYTES(BUF_BYTES)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_if),
        .result(res_if),
        .cfg   (cfg_if)
    );

    // Tracker copy: registers and connection state as the block should hold them
    logic [31:0]           reg_server = '0;
    logic [15:0]           reg_port   = '0;
    logic [31:0]           reg_iseq   = '0;
    tcpr_pkg::conn_state_t trk_state  = tcpr_pkg::CS_CLOSED;
    logic [31:0]           trk_local  = '0;
    logic [31:0]           trk_peer   = '0;
    logic [22:0]           trk_stored = '0;
    logic                  trk_done   = 1'b0;

    tx_req_t  pending_replies[$];
    dir_row_t dir_rows[$];

    int n_items      = 0;
    int n_directed   = 0;
    int n_replies    = 0;
    int n_errors     = 0;
    int n_closed     = 0;
    int n_stored     = 0;
    int n_refused    = 0;
    int quiet_cycles = 0;
    int gap_pct      = 0;
    int stall_pct    = 0;
    bit hold_token   = 1'b0;
    bit hold_seen    = 1'b0;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic seg_item_t mk_item(input logic [1:0] func, input logic [31:0] src,
                                          input logic [15:0] dport, input logic [7:0] flags,
                                          input logic [31:0] seq, input logic [31:0] ackn,
                                          input logic [15:0] len);
        seg_item_t it;
        it = '{func: func, src: src, dport: dport, flags: flags, seq: seq, ackn: ackn, len: len};
        return it;
    endfunction

    function automatic tx_req_t mk_req(input tcpr_pkg::send_kind_t kind,
                                       input logic [31:0] seq, input logic [31:0] ackn,
                                       input tcpr_pkg::conn_state_t state, input logic done);
        tx_req_t r;
        r = '{kind: kind, seq: seq, ackn: ackn, state: state, acc: 1'b0, off: '0,
              done: done, last: 1'b1};
        return r;
    endfunction

    function automatic string describe_reply(input tx_req_t r);
        return $sformatf("kind=%0d seq=%h ack=%h state=%0d acc=%0d off=%h done=%0d last=%0d",
                         r.kind, r.seq, r.ackn, r.state, r.acc, r.off, r.done, r.last);
    endfunction

    // Advance the tracker copy by one item and return the reply beats it causes.
    function automatic int track_item(input seg_item_t it, output tx_req_t r0,
                                      output tx_req_t r1);
        tx_req_t     r[2];
        int          n;
        logic [31:0] sum;
        logic        hit;
        n    = 0;
        r[0] = '0;
        r[1] = '0;
        hit  = (it.func == tcpr_pkg::FUNC_SEGMENT) && (it.src == reg_server)
            && (it.dport == reg_port);
        if (it.func == tcpr_pkg::FUNC_OPEN)
        begin
            trk_local  = reg_iseq;
            trk_peer   = '0;
            trk_stored = '0;
            trk_done   = 1'b0;
            trk_state  = tcpr_pkg::CS_SYN_SENT;
            r[0].kind  = tcpr_pkg::SK_SYN;
            r[0].seq   = trk_local;
            n          = 1;
        end
        else if (it.func == tcpr_pkg::FUNC_SENT)
        begin
            r[0].kind = tcpr_pkg::SK_DATA;
            r[0].seq  = trk_local;
            r[0].ackn = trk_peer;
            trk_local = trk_local + 32'(it.len);
            n         = 1;
        end
        else if (hit && trk_state == tcpr_pkg::CS_SYN_SENT)
        begin
            if ((it.flags & tcpr_pkg::FLAG_SYN) != 0 && (it.flags & tcpr_pkg::FLAG_ACK) != 0)
            begin
                trk_peer  = it.seq + 32'd1;
                trk_local = it.ackn;
                trk_state = tcpr_pkg::CS_ESTABLISHED;
            end
            n = 1;
        end
        else if (hit && trk_state == tcpr_pkg::CS_ESTABLISHED)
        begin
            if (it.len != 0)
            begin
                sum       = 32'(trk_stored) + 32'(it.len);
                trk_peer  = it.seq + 32'(it.len);
                r[n].kind = tcpr_pkg::SK_ACK;
                r[n].seq  = trk_local;
                r[n].ackn = trk_peer;
                if (sum < BUF_BYTES)
                begin
                    r[n].acc   = 1'b1;
                    r[n].off   = trk_stored[21:0];
                    trk_stored = sum[22:0];
                    n_stored++;
                end
                else
                    n_refused++;
                n++;
            end
            if ((it.flags & tcpr_pkg::FLAG_FIN) != 0)
            begin
                trk_peer  = trk_peer + 32'd1;
                r[n].kind = tcpr_pkg::SK_ACK;
                r[n].seq  = trk_local;
                r[n].ackn = trk_peer;
                trk_state = tcpr_pkg::CS_CLOSED;
                trk_done  = 1'b1;
                n_closed++;
                n++;
            end
            if (n == 0)
                n = 1;
        end
        else
            n = 1;
        for (int k = 0; k < n; k++)
        begin
            r[k].state = trk_state;
            r[k].done  = trk_done;
            r[k].last  = (k == n - 1);
        end
        r0 = r[0];
        r1 = r[1];
        return n;
    endfunction

    function automatic logic [15:0] rand_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            return 16'd0;
        else if (pick < 25)
            return 16'hFFFF;
        else if (pick < 70)
            return 16'($urandom_range(1, 1460));
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic seg_item_t data_seg(input logic [15:0] len);
        return mk_item(tcpr_pkg::FUNC_SEGMENT, reg_server, reg_port,
                       (8'($urandom) & ~tcpr_pkg::FLAG_FIN) | tcpr_pkg::FLAG_ACK, trk_peer,
                       $urandom, len);
    endfunction

    // Near misses on address and port, stray func codes and unsolicited segments.
    function automatic seg_item_t mk_noise();
        case ($urandom_range(0, 3))
            0: return mk_item(2'($urandom), $urandom, 16'($urandom), 8'($urandom), $urandom,
                              $urandom, 16'($urandom));
            1: return mk_item(tcpr_pkg::FUNC_SEGMENT, reg_server,
                              reg_port ^ (16'd1 << $urandom_range(0, 15)), 8'($urandom),
                              $urandom, $urandom, rand_len());
            2: return mk_item(tcpr_pkg::FUNC_SEGMENT,
                              reg_server ^ (32'd1 << $urandom_range(0, 31)),
                              reg_port, 8'($urandom), $urandom, $urandom, rand_len());
            default: return mk_item(tcpr_pkg::FUNC_SEGMENT, reg_server, reg_port,
                                    8'($urandom), $urandom, $urandom, rand_len());
        endcase
    endfunction

    // Call at a rising edge; returns at the edge that takes the beat.
    task automatic send_item(input seg_item_t it, input logic typed, input tx_req_t want);
        tx_req_t r0;
        tx_req_t r1;
        int      n;
        while ($urandom_range(0, 99) < gap_pct)
        begin
            item_if.valid <= 1'b0;
            @(posedge clk);
        end
        item_if.valid            <= 1'b1;
        item_if.func             <= it.func;
        item_if.source_address   <= it.src;
        item_if.dest_port        <= it.dport;
        item_if.tcp_flags        <= it.flags;
        item_if.peer_sequence_in <= it.seq;
        item_if.peer_ack_in      <= it.ackn;
        item_if.byte_count       <= it.len;
        @(negedge clk);
        while (!item_if.ready)
            @(negedge clk);
        @(posedge clk);
        n_items++;
        n = track_item(it, r0, r1);
        if (typed)
            pending_replies.push_back(want);
        else
        begin
            pending_replies.push_back(r0);
            if (n == 2)
                pending_replies.push_back(r1);
        end
    endtask

    task automatic cfg_write(input tcpr_pkg::cfg_index_t idx, input logic [31:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(negedge clk);
        while (!cfg_if.ready)
            @(negedge clk);
        @(posedge clk);
        case (idx)
            tcpr_pkg::CFG_SERVER_ADDRESS:   reg_server = value;
            tcpr_pkg::CFG_CLIENT_PORT:      reg_port   = value[15:0];
            tcpr_pkg::CFG_INITIAL_SEQUENCE: reg_iseq   = value;
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [31:0] addr, input logic [15:0] port,
                                input logic [31:0] iseq);
        cfg_write(tcpr_pkg::CFG_SERVER_ADDRESS, addr);
        cfg_write(tcpr_pkg::CFG_CLIENT_PORT, 32'(port));
        cfg_write(tcpr_pkg::CFG_INITIAL_SEQUENCE, iseq);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic settle();
        item_if.valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_download(input int n_segs, input logic bulk);
        int fill;
        int pick;
        send_item(mk_item(tcpr_pkg::FUNC_OPEN, $urandom, 16'($urandom), 8'($urandom),
                          $urandom, $urandom, 16'($urandom)), 1'b0, '0);
        while (!bulk && $urandom_range(0, 99) < 30)
            send_item(mk_noise(), 1'b0, '0);
        send_item(mk_item(tcpr_pkg::FUNC_SEGMENT, reg_server, reg_port,
                          8'($urandom) | tcpr_pkg::FLAG_SYN | tcpr_pkg::FLAG_ACK, $urandom,
                          $urandom, 16'($urandom)), 1'b0, '0);
        if (bulk)
        begin
            // Fill the buffer, land exactly on the limit, take one byte short of it, then overrun.
            while (32'(trk_stored) + 32'd65535 < BUF_BYTES)
                send_item(data_seg(16'hFFFF), 1'b0, '0);
            fill = int'(BUF_BYTES) - int'(trk_stored);
            send_item(data_seg(16'(fill)), 1'b0, '0);
            if (fill > 1)
                send_item(data_seg(16'(fill - 1)), 1'b0, '0);
            send_item(data_seg(16'd1), 1'b0, '0);
        end
        for (int i = 0; i < n_segs; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
                send_item(mk_item(tcpr_pkg::FUNC_SENT, $urandom, 16'($urandom), 8'($urandom),
                                  $urandom, $urandom, rand_len()), 1'b0, '0);
            else if (pick < 22 && !bulk)
                send_item(mk_noise(), 1'b0, '0);
            else
                send_item(data_seg(rand_len()), 1'b0, '0);
        end
        if (bulk || $urandom_range(0, 99) < 75)
            send_item(mk_item(tcpr_pkg::FUNC_SEGMENT, reg_server, reg_port,
                              8'($urandom) | tcpr_pkg::FLAG_FIN, trk_peer, $urandom,
                              ($urandom_range(0, 1) != 0) ? rand_len() : 16'd0), 1'b0, '0);
    endtask

    // Reply side: random stalls, plus a long hold-off whenever the token flips.
    initial
    begin
        res_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_token != hold_seen)
            begin
                hold_seen = hold_token;
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            res_if.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Sample at the falling edge: what is seen here is what the next rising edge takes.
    always @(negedge clk)
    begin
        tx_req_t seen;
        tx_req_t want;
        if (rst_n)
        begin
            if (res_if.valid && res_if.ready)
            begin
                seen = '{kind: res_if.send_kind, seq: res_if.send_sequence,
                         ackn: res_if.send_ack_number, state: res_if.connection_state,
                         acc: res_if.store_accepted, off: res_if.store_offset,
                         done: res_if.download_done, last: res_if.last_of_run};
                n_replies++;
                if (pending_replies.size() == 0)
                begin
                    n_errors++;
                    $display("%0t: reply beat with nothing expected\n    expected none\n"
                             , $time, "    actual   %s", describe_reply(seen));
                end
                else
                begin
                    want = pending_replies.pop_front();
                    if (seen !== want)
                    begin
                        n_errors++;
                        $display("%0t: reply mismatch\n    expected %s\n    actual   %s",
                                 $time, describe_reply(want), describe_reply(seen));
                    end
                end
            end
            if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("%0t: no beat on any channel for %0d cycles", $time, QUIET_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        rst_n                    = 1'b0;
        item_if.valid            = 1'b0;
        item_if.func             = '0;
        item_if.source_address   = '0;
        item_if.dest_port        = '0;
        item_if.tcp_flags        = '0;
        item_if.peer_sequence_in = '0;
        item_if.peer_ack_in      = '0;
        item_if.byte_count       = '0;
        cfg_if.valid             = 1'b0;
        cfg_if.index             = tcpr_pkg::CFG_SERVER_ADDRESS;
        cfg_if.data              = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        program_regs(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);

        // Directed table: typed replies where they are plain, the tracker copy elsewhere.
        dir_rows.push_back('{mk_item(tcpr_pkg::FUNC_SEGMENT, '1, '1,
                                     tcpr_pkg::FLAG_SYN | tcpr_pkg::FLAG_ACK, 0, 0, 0), 1'b1,
                             mk_req(tcpr_pkg::SK_NONE, 0, 0, tcpr_pkg::CS_CLOSED, 1'b0)});
        dir_rows.push_back('{mk_item(FUNC_UNUSED, '1, '1, '1, '1, '1, '1), 1'b1,
                             mk_req(tcpr_pkg::SK_NONE, 0, 0, tcpr_pkg::CS_CLOSED, 1'b0)});
        dir_rows.push_back('{mk_item(tcpr_pkg::FUNC_SENT, 0, 0, 0, 0, 0, 16'hFFFF), 1'b1,
                             mk_req(tcpr_pkg::SK_DATA, 0, 0, tcpr_pkg::CS_CLOSED, 1'b0)});
        dir_rows.push_back('{mk_item(tcpr_pkg::FUNC_OPEN, 0, 0, 0, 32'h1234_5678, 0, 0), 1'b1,
                             mk_req(tcpr_pkg::SK_SYN, 32'hFFFF_FFFF, 0, tcpr_pkg::CS_SYN_SENT,
                                    1'b0)});
        dir_rows.push_back('{mk_item(tcpr_pkg::FUNC_SEGMENT, 32'hFFFF_FFFE, '1,
                                     tcpr_pkg::FLAG_SYN | tcpr_pkg::FLAG_ACK, 5, 6, 0), 1'b1,
                             mk_req(tcpr_pkg::SK_NONE, 0, 0, tcpr_pkg::CS_SYN_SENT, 1'b0)});
        dir_rows.push_back('{mk_item(tcpr_pkg::FUNC_SEGMENT, '1, 16'h7FFF,
                                     tcpr_pkg::FLAG_SYN | tcpr_pkg::FLAG_ACK, 5, 6, 0), 1'b1,
                             mk_req(tcpr_pkg::SK_NONE, 0, 0, tcpr_pkg::CS_SYN_SENT, 1'b0)});
        dir_rows.push_back('{mk_item(tcpr_pkg::FUNC_SEGMENT, '1, '1, tcpr_pkg::FLAG_ACK, 5, 6,
                                     0), 1'b1,
                             mk_req(tcpr_pkg::SK_NONE, 0, 0, tcpr_pkg::CS_SYN_SENT, 1'b0)});
        dir_rows.push_back('{mk_item(tcpr_pkg::FUNC_SEGMENT, '1, '1, tcpr_pkg::FLAG_SYN, 5, 6,
                                     0), 1'b1,
                             mk_req(tcpr_pkg::SK_NONE, 0, 0, tcpr_pkg::CS_SYN_SENT, 1'b0)});
        dir_rows.push_back('{mk_item(tcpr_pkg::FUNC_SEGMENT, '1, '1,
                                     tcpr_pkg::FLAG_SYN | tcpr_pkg::FLAG_ACK, 32'hFFFF_FFFF,
                                     32'h1000, 0), 1'b1,
                             mk_req(tcpr_pkg::SK_NONE, 0, 0, tcpr_pkg::CS_ESTABLISHED,
                                    1'b0)});
        dir_rows.push_back('{mk_item(tcpr_pkg::FUNC_SENT, 0, 0, 0, 0, 0, 0), 1'b1,
                             mk_req(tcpr_pkg::SK_DATA, 32'h1000, 0, tcpr_pkg::CS_ESTABLISHED,
                                    1'b0)});
        dir_rows.push_back('{mk_item(tcpr_pkg::FUNC_SEGMENT, '1, '1, tcpr_pkg::FLAG_ACK, 32'h77,
                                     0, 0), 1'b1,
                             mk_req(tcpr_pkg::SK_NONE, 0, 0, tcpr_pkg::CS_ESTABLISHED,
                                    1'b0)});
        dir_rows.push_back('{mk_item(tcpr_pkg::FUNC_SEGMENT, '1, '1,
                                     tcpr_pkg::FLAG_ACK | FLAG_PSH, 32'hFFFF_FFF0, 0,
                                     16'hFFFF), 1'b0, '0});
        dir_rows.push_back('{mk_item(tcpr_pkg::FUNC_SEGMENT, '1, '1, tcpr_pkg::FLAG_ACK, 0, 0,
                                     1), 1'b0, '0});
        dir_rows.push_back('{mk_item(tcpr_pkg::FUNC_SENT, 0, 0, 0, 0, 0, 16'hFFFF), 1'b0, '0});
        dir_rows.push_back('{mk_item(tcpr_pkg::FUNC_SEGMENT, 0, '1,
                                     tcpr_pkg::FLAG_ACK | tcpr_pkg::FLAG_FIN, 0, 0, 10), 1'b1,
                             mk_req(tcpr_pkg::SK_NONE, 0, 0, tcpr_pkg::CS_ESTABLISHED,
                                    1'b0)});
        dir_rows.push_back('{mk_item(tcpr_pkg::FUNC_SEGMENT, '1, '1,
                                     tcpr_pkg::FLAG_ACK | FLAG_PSH | tcpr_pkg::FLAG_FIN,
                                     32'h8000_0000, 0, 16'd512), 1'b0, '0});
        dir_rows.push_back('{mk_item(tcpr_pkg::FUNC_SEGMENT, '1, '1,
                                     tcpr_pkg::FLAG_ACK | tcpr_pkg::FLAG_FIN, 0, 0, 100), 1'b1,
                             mk_req(tcpr_pkg::SK_NONE, 0, 0, tcpr_pkg::CS_CLOSED, 1'b1)});
        dir_rows.push_back('{mk_item(tcpr_pkg::FUNC_OPEN, '1, '1, '1, '1, '1, '1), 1'b1,
                             mk_req(tcpr_pkg::SK_SYN, 32'hFFFF_FFFF, 0, tcpr_pkg::CS_SYN_SENT,
                                    1'b0)});
        dir_rows.push_back('{mk_item(tcpr_pkg::FUNC_SEGMENT, '1, '1, '1, 0, 32'hFFFF_FFFF, 0),
                             1'b1,
                             mk_req(tcpr_pkg::SK_NONE, 0, 0, tcpr_pkg::CS_ESTABLISHED,
                                    1'b0)});
        dir_rows.push_back('{mk_item(tcpr_pkg::FUNC_SEGMENT, '1, '1,
                                     tcpr_pkg::FLAG_ACK | tcpr_pkg::FLAG_FIN, 0, 0, 0), 1'b0,
                             '0});
        dir_rows.push_back('{mk_item(FUNC_UNUSED, 0, 0, 0, 0, 0, 0), 1'b1,
                             mk_req(tcpr_pkg::SK_NONE, 0, 0, tcpr_pkg::CS_CLOSED, 1'b1)});
        dir_rows.push_back('{mk_item(tcpr_pkg::FUNC_SENT, 0, 0, 0, 0, 0, 1), 1'b0, '0});
        foreach (dir_rows[i])
            send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
        n_directed = n_items;

        for (int ph = 0; ph < 4; ph++)
        begin
            int target;
            settle();
            case (ph)
                0:
                begin
                    program_regs($urandom, 16'($urandom), $urandom);
                    gap_pct = 0;
                    stall_pct <= 0;
                end
                1:
                begin
                    program_regs(32'd0, 16'd0, 32'd0);
                    gap_pct = 57;
                    stall_pct <= 0;
                end
                2:
                begin
                    program_regs($urandom, 16'($urandom), $urandom);
                    gap_pct = 0;
                    stall_pct <= 57;
                end
                default:
                begin
                    program_regs($urandom, 16'($urandom), $urandom);
                    gap_pct = 18;
                    stall_pct <= 18;
                end
            endcase
            target = n_items + PHASE_ITEMS;
            if (ph == 0)
            begin
                // Hold the reply side off while a full-buffer download keeps the input busy.
                hold_token <= ~hold_token;
                run_download(12, 1'b1);
            end
            while (n_items < target)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_item(mk_noise(), 1'b0, '0);
                else
                    run_download($urandom_range(2, 20), 1'b0);
            end
        end

        item_if.valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d items (%0d from the directed table) over four idling phases.",
                 n_items, n_directed);
        $display("Checked %0d reply beats, %0d mismatches; FIN closes %0d, stored %0d, full %0d.",
                 n_replies, n_errors, n_closed, n_stored, n_refused);
        if (n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
